// ===== rtl/core/sfp_pkg.sv =====
// Shared types, codes and CRC helper for the serial frame parser.
package sfp_pkg;

	typedef enum logic [1:0] {
		REQ_BYTE       = 2'd0,
		REQ_RD_MOTION  = 2'd1,
		REQ_RD_REFEREE = 2'd2,
		REQ_CLEAR      = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_MOTION_OK    = 3'd1,
		EV_REFEREE_OK   = 3'd2,
		EV_BAD_CMD      = 3'd3,
		EV_TOO_LONG     = 3'd4,
		EV_CRC_FAIL     = 3'd5,
		EV_LEN_MISMATCH = 3'd6
	} event_t;

	typedef enum logic [2:0] {
		PH_HUNT1 = 3'd0,
		PH_HUNT2 = 3'd1,
		PH_CMD   = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CRC   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_READ   = 2'd1,
		BK_COPY   = 2'd2,
		BK_FINISH = 2'd3
	} bk_state_t;

	typedef enum logic [2:0] {
		CFG_HEADER_FIRST  = 3'd0,
		CFG_HEADER_SECOND = 3'd1,
		CFG_MOTION_CMD    = 3'd2,
		CFG_REFEREE_CMD   = 3'd3,
		CFG_MAX_PAYLOAD   = 3'd4,
		CFG_CRC_POLY      = 3'd5,
		CFG_CRC_REFLECTED = 3'd6,
		CFG_CRC_INIT      = 3'd7
	} cfg_idx_t;

	localparam logic [7:0] RST_HEADER_FIRST  = 8'h42;
	localparam logic [7:0] RST_HEADER_SECOND = 8'h52;
	localparam logic [7:0] RST_MOTION_CMD    = 8'hCD;
	localparam logic [7:0] RST_REFEREE_CMD   = 8'h00;
	localparam logic [7:0] RST_MAX_PAYLOAD   = 8'hFF;
	localparam logic [7:0] RST_CRC_POLY      = 8'h07;
	localparam logic       RST_CRC_REFLECTED = 1'b0;
	localparam logic [7:0] RST_CRC_INIT      = 8'h00;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] motion_cmd;
		logic [7:0] referee_cmd;
		logic [7:0] max_payload;
		logic [7:0] crc_poly;
		logic       crc_reflected;
		logic [7:0] crc_init;
	} cfg_t;

	typedef struct packed {
		req_t       kind;
		event_t     ev;
		logic [7:0] len;
		logic [5:0] idx;
	} fe_item_t;

	typedef struct packed {
		logic       done;
		logic [7:0] raddr;
	} bk2fe_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] len;
		logic [7:0] rd;
		logic       ready;
	} res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
			input logic [7:0] poly, input logic refl);
		logic [7:0] c;
		logic [7:0] rp;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			rp[i] = poly[7 - i];
		end
		for (int i = 0; i < 8; i++) begin
			if (refl) begin
				c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
			end else begin
				c = c[7] ? ((c << 1) ^ poly) : (c << 1);
			end
		end
		return c;
	endfunction

	function automatic logic needs_copy(input event_t ev, input logic [7:0] len);
		return (ev == EV_REFEREE_OK) || ((ev == EV_MOTION_OK) && (len != 8'd0));
	endfunction

endpackage

// ===== rtl/core/sfp_queue.sv =====
// Short FIFO of classified items between the parser front and the commit back.
module sfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfp_pkg::fe_item_t push_item,
	output logic              full,
	input  logic              pop,
	output sfp_pkg::fe_item_t head,
	output logic              empty
);
	import sfp_pkg::*;

	fe_item_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

// ===== rtl/core/sfp_front.sv =====
// Parser front: header hunt, CRC accumulation, payload staging and frame classification.
module sfp_front #(
	parameter int STAGE_DEPTH   = 256,
	parameter int MOTION_BYTES  = 32,
	parameter int REFEREE_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfp_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  sfp_pkg::req_t     in_kind,
	input  logic [7:0]        in_byte,
	input  logic [5:0]        in_idx,
	input  logic              q_full,
	output logic              push,
	output sfp_pkg::fe_item_t push_item,
	input  sfp_pkg::bk2fe_t   bk,
	output logic [7:0]        stg_rdata
);
	import sfp_pkg::*;

	localparam int STG_AW = $clog2(STAGE_DEPTH);

	phase_t     phase_q, phase_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] crc_q, crc_d;
	logic       busy_q;

	logic [7:0] stg_mem [STAGE_DEPTH];
	logic [7:0] stg_rdata_q;

	logic       byte_acc;
	logic       use_init;
	logic [7:0] crc_nx;
	logic       cmd_bad;
	logic       len_bad;
	event_t     ev_o;
	logic [7:0] len_o;
	logic       stg_we;

	assign in_ready = !q_full && !(busy_q && (phase_q == PH_DATA));
	assign push     = in_valid && in_ready;
	assign byte_acc = push && (in_kind == REQ_BYTE);

	assign use_init = (phase_q == PH_HUNT2) ? (in_byte != cfg.header_second) :
		!((phase_q == PH_CMD) || (phase_q == PH_LEN) || (phase_q == PH_DATA));
	assign crc_nx   = crc8_step(use_init ? cfg.crc_init : crc_q, in_byte, cfg.crc_poly,
		cfg.crc_reflected);
	assign cmd_bad  = (in_byte != cfg.motion_cmd) && (in_byte != cfg.referee_cmd);
	assign len_bad  = (in_byte > cfg.max_payload) || ({1'b0, in_byte} > 9'(STAGE_DEPTH));

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		crc_d   = crc_q;
		if (byte_acc) begin
			unique case (phase_q)
				PH_HUNT2: begin
					if (in_byte == cfg.header_second) begin
						crc_d   = crc_nx;
						phase_d = PH_CMD;
					end else if (in_byte == cfg.header_first) begin
						crc_d = crc_nx;
					end else begin
						phase_d = PH_HUNT1;
					end
				end
				PH_CMD: begin
					if (cmd_bad) begin
						phase_d = PH_HUNT1;
					end else begin
						cmd_d   = in_byte;
						crc_d   = crc_nx;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					if (len_bad) begin
						phase_d = PH_HUNT1;
					end else begin
						len_d   = in_byte;
						cnt_d   = '0;
						crc_d   = crc_nx;
						phase_d = (in_byte == 8'd0) ? PH_CRC : PH_DATA;
					end
				end
				PH_DATA: begin
					cnt_d = cnt_q + 8'd1;
					crc_d = crc_nx;
					if (cnt_d >= len_q) begin
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					phase_d = PH_HUNT1;
				end
				default: begin
					phase_d = PH_HUNT1;
					if (in_byte == cfg.header_first) begin
						crc_d   = crc_nx;
						phase_d = PH_HUNT2;
					end
				end
			endcase
		end
	end

	always_comb begin
		ev_o   = EV_NONE;
		len_o  = '0;
		stg_we = 1'b0;
		if (byte_acc) begin
			unique case (phase_q)
				PH_CMD: begin
					if (cmd_bad) begin
						ev_o = EV_BAD_CMD;
					end
				end
				PH_LEN: begin
					if (len_bad) begin
						ev_o  = EV_TOO_LONG;
						len_o = in_byte;
					end
				end
				PH_DATA: begin
					stg_we = 1'b1;
				end
				PH_CRC: begin
					len_o = len_q;
					if (in_byte != crc_q) begin
						ev_o = EV_CRC_FAIL;
					end else if (cmd_q == cfg.referee_cmd) begin
						ev_o = (len_q == 8'(REFEREE_BYTES)) ? EV_REFEREE_OK : EV_LEN_MISMATCH;
					end else begin
						ev_o = (len_q <= 8'(MOTION_BYTES)) ? EV_MOTION_OK : EV_LEN_MISMATCH;
					end
				end
				default: begin
					ev_o = EV_NONE;
				end
			endcase
		end
	end

	assign push_item = '{kind: in_kind, ev: ev_o, len: len_o, idx: in_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			cmd_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			crc_q   <= RST_CRC_INIT;
			busy_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			if (byte_acc && needs_copy(ev_o, len_o)) begin
				busy_q <= 1'b1;
			end else if (bk.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_mem[cnt_q[STG_AW-1:0]] <= in_byte;
		end
		stg_rdata_q <= stg_mem[bk.raddr[STG_AW-1:0]];
	end

	assign stg_rdata = stg_rdata_q;

`ifndef SYNTHESIS
	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n) stg_we |-> !busy_q)
		else $error("staging store written during a commit copy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (cnt_q < len_q))
		else $error("payload count reached length while still in payload phase");
`endif

endmodule

// ===== rtl/core/sfp_back.sv =====
// Commit back: copies staged payloads into the stores, serves reads and the ready flag.
module sfp_back #(
	parameter int MOTION_BYTES  = 32,
	parameter int REFEREE_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sfp_pkg::fe_item_t q_head,
	output logic              q_pop,
	input  logic [7:0]        stg_rdata,
	output sfp_pkg::bk2fe_t   bk,
	output logic              out_valid,
	input  logic              out_ready,
	output sfp_pkg::res_t     out_res
);
	import sfp_pkg::*;

	localparam int MOT_AW = (MOTION_BYTES > 1) ? $clog2(MOTION_BYTES) : 1;
	localparam int REF_AW = (REFEREE_BYTES > 1) ? $clog2(REFEREE_BYTES) : 1;

	bk_state_t  state_q, state_d;
	fe_item_t   cur_q;
	logic [7:0] n_q;
	logic [7:0] iss_q;
	logic       wp_s1;
	logic [7:0] wa_s1;
	logic       flag_q, flag_d;
	logic       out_valid_q;
	res_t       out_res_q;

	logic [7:0]              mot_mem [MOTION_BYTES];
	logic [7:0]              ref_mem [REFEREE_BYTES];
	logic [MOTION_BYTES-1:0] mot_vld_q;
	logic [REFEREE_BYTES-1:0] ref_vld_q;
	logic [7:0]              mot_rd_q;
	logic [7:0]              ref_rd_q;
	logic                    mot_hit_q;
	logic                    ref_hit_q;

	logic       out_free;
	logic       head_read;
	logic       head_copy;
	logic       load;
	logic       issue;
	logic       mot_hit;
	logic       ref_hit;
	fe_item_t   src;
	logic [7:0] rd_val;

	assign out_free  = !out_valid_q || out_ready;
	assign head_read = (q_head.kind == REQ_RD_MOTION) || (q_head.kind == REQ_RD_REFEREE);
	assign head_copy = (q_head.kind == REQ_BYTE) && needs_copy(q_head.ev, q_head.len);
	assign mot_hit   = ({1'b0, q_head.idx} < 7'(MOTION_BYTES)) &&
		mot_vld_q[q_head.idx[MOT_AW-1:0]];
	assign ref_hit   = ({1'b0, q_head.idx} < 7'(REFEREE_BYTES)) &&
		ref_vld_q[q_head.idx[REF_AW-1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					if (head_read) begin
						state_d = BK_READ;
					end else if (head_copy) begin
						state_d = BK_COPY;
					end
				end
			end
			BK_READ: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			BK_COPY: begin
				if ((iss_q == n_q) && !wp_s1) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		load  = 1'b0;
		issue = 1'b0;
		bk    = '{done: 1'b0, raddr: iss_q};
		unique case (state_q)
			BK_IDLE: begin
				q_pop = !q_empty && out_free;
				load  = q_pop && !head_read && !head_copy;
			end
			BK_READ: begin
				load = out_free;
			end
			BK_COPY: begin
				issue = (iss_q < n_q);
			end
			BK_FINISH: begin
				load    = out_free;
				bk.done = out_free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	assign src = (state_q == BK_IDLE) ? q_head : cur_q;

	always_comb begin
		case (src.kind)
			REQ_RD_MOTION:  rd_val = mot_hit_q ? mot_rd_q : 8'd0;
			REQ_RD_REFEREE: rd_val = ref_hit_q ? ref_rd_q : 8'd0;
			default:        rd_val = 8'd0;
		endcase
		flag_d = flag_q;
		if (load && (src.kind == REQ_CLEAR)) begin
			flag_d = 1'b0;
		end else if (load && (src.kind == REQ_BYTE) && (src.ev == EV_REFEREE_OK)) begin
			flag_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			iss_q       <= '0;
			wp_s1       <= 1'b0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			mot_vld_q   <= '0;
			ref_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			flag_q  <= flag_d;
			wp_s1   <= issue;
			if (q_pop) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 8'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wp_s1 && (cur_q.ev == EV_MOTION_OK)) begin
				mot_vld_q[wa_s1[MOT_AW-1:0]] <= 1'b1;
			end
			if (wp_s1 && (cur_q.ev == EV_REFEREE_OK)) begin
				ref_vld_q[wa_s1[REF_AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_head;
			n_q       <= (q_head.ev == EV_REFEREE_OK) ? 8'(REFEREE_BYTES) : q_head.len;
			mot_rd_q  <= mot_mem[q_head.idx[MOT_AW-1:0]];
			ref_rd_q  <= ref_mem[q_head.idx[REF_AW-1:0]];
			mot_hit_q <= mot_hit;
			ref_hit_q <= ref_hit;
		end
		wa_s1 <= iss_q;
		if (wp_s1 && (cur_q.ev == EV_MOTION_OK)) begin
			mot_mem[wa_s1[MOT_AW-1:0]] <= stg_rdata;
		end
		if (wp_s1 && (cur_q.ev == EV_REFEREE_OK)) begin
			ref_mem[wa_s1[REF_AW-1:0]] <= stg_rdata;
		end
		if (load) begin
			out_res_q <= '{ev: src.ev, len: src.len, rd: rd_val, ready: flag_d};
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

`ifndef SYNTHESIS
	a_copy_only: assert property (@(posedge clk) disable iff (!arst_n)
		wp_s1 |-> (state_q == BK_COPY))
		else $error("store write outside a commit copy");
	a_ref_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_res_q.ev == EV_REFEREE_OK)) |-> out_res_q.ready)
		else $error("referee accept reported without ready flag");
`endif

endmodule

// ===== rtl/core/serial_frame_parser_crc8.sv =====
// Top level of the serial frame parser with CRC-8 check and payload stores.
//
//   channel  direction  beat fields (low bit first)
//   s_*      in         tuser: req_type; tdata: rx_byte, read_index
//   m_*      out        tdata: frame_event, payload_length, read_data, referee_ready
//   cfg_*    in         cfg_index selects the register, cfg_wdata is written
//
// The front takes one beat per cycle unless the queue is full or a pending copy holds back
// the next frame's payload bytes, and classifies it through a four-entry queue. Received
// bytes that start no copy and flag clears leave the back one per cycle while the output is
// free; a store read waits in the read state for the registered store read port. A committed
// frame is copied from the staging store through the copy and finish states.
// Reset clears the store valid bits at once, so no clearing pass is needed.
module serial_frame_parser_crc8 #(
	parameter int STAGE_DEPTH   = 256,
	parameter int MOTION_BYTES  = 32,
	parameter int REFEREE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte, read_index, zero fill
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // frame_event, payload_length, read_data, referee_ready, zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);
	import sfp_pkg::*;

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	fe_item_t push_item;
	fe_item_t head;
	bk2fe_t   bk;
	logic [7:0] stg_rdata;
	res_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{header_first: RST_HEADER_FIRST, header_second: RST_HEADER_SECOND,
				motion_cmd: RST_MOTION_CMD, referee_cmd: RST_REFEREE_CMD,
				max_payload: RST_MAX_PAYLOAD, crc_poly: RST_CRC_POLY,
				crc_reflected: RST_CRC_REFLECTED, crc_init: RST_CRC_INIT};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata;
				CFG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata;
				CFG_MOTION_CMD:    cfg_q.motion_cmd    <= cfg_wdata;
				CFG_REFEREE_CMD:   cfg_q.referee_cmd   <= cfg_wdata;
				CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_wdata;
				CFG_CRC_POLY:      cfg_q.crc_poly      <= cfg_wdata;
				CFG_CRC_REFLECTED: cfg_q.crc_reflected <= cfg_wdata[0];
				CFG_CRC_INIT:      cfg_q.crc_init      <= cfg_wdata;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	sfp_front #(
		.STAGE_DEPTH   (STAGE_DEPTH),
		.MOTION_BYTES  (MOTION_BYTES),
		.REFEREE_BYTES (REFEREE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (req_t'(s_tuser)),
		.in_byte   (s_tdata[7:0]),
		.in_idx    (s_tdata[13:8]),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item),
		.bk        (bk),
		.stg_rdata (stg_rdata)
	);

	sfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	sfp_back #(
		.MOTION_BYTES  (MOTION_BYTES),
		.REFEREE_BYTES (REFEREE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head),
		.q_pop     (pop),
		.stg_rdata (stg_rdata),
		.bk        (bk),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {4'd0, res.ready, res.rd, res.len, res.ev};

endmodule

// ===== tb/serial_frame_parser_crc8_tb.sv =====
// Self-checking testbench for the serial frame parser: directed and random beats.
`timescale 1ns / 100ps

module serial_frame_parser_crc8_tb;
	import sfp_pkg::*;

	localparam int STAGE_N = 256;
	localparam int MOT_N   = 32;
	localparam int REF_N   = 16;

	typedef struct packed {
		req_t       kind;
		logic [7:0] data;
		logic [5:0] idx;
	} beat_t;

	class frame_outcome_board;
		logic [7:0] hf, hs, mcmd, rcmd, maxlen, poly, init;
		logic       refl;
		logic [7:0] crc_table [256];
		phase_t     phase;
		logic [7:0] cmd, flen, count, crc;
		logic [7:0] staging [STAGE_N];
		logic [7:0] motion [MOT_N];
		logic [7:0] referee [REF_N];
		logic       ready;
		res_t       pending [$];
		int         mismatches;
		int         checked;
		int         beats_noted;
		int         ev_seen [8];

		function new();
			hf = RST_HEADER_FIRST;
			hs = RST_HEADER_SECOND;
			mcmd = RST_MOTION_CMD;
			rcmd = RST_REFEREE_CMD;
			maxlen = RST_MAX_PAYLOAD;
			poly = RST_CRC_POLY;
			refl = RST_CRC_REFLECTED;
			init = RST_CRC_INIT;
			phase = PH_HUNT1;
			cmd = 8'd0;
			flen = 8'd0;
			count = 8'd0;
			crc = RST_CRC_INIT;
			ready = 1'b0;
			foreach (motion[i]) motion[i] = 8'd0;
			foreach (referee[i]) referee[i] = 8'd0;
			foreach (ev_seen[i]) ev_seen[i] = 0;
			mismatches = 0;
			checked = 0;
			beats_noted = 0;
			build_table();
		endfunction

		function void build_table();
			logic [7:0] rp;
			logic [7:0] c;
			for (int k = 0; k < 8; k++) begin
				rp[k] = poly[7 - k];
			end
			for (int v = 0; v < 256; v++) begin
				c = 8'(v);
				for (int k = 0; k < 8; k++) begin
					if (refl) begin
						c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
					end else begin
						c = c[7] ? ((c << 1) ^ poly) : (c << 1);
					end
				end
				crc_table[v] = c;
			end
		endfunction

		function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
			return crc_table[c ^ b];
		endfunction

		function void write_reg(cfg_idx_t i, logic [7:0] v);
			case (i)
				CFG_HEADER_FIRST:  hf = v;
				CFG_HEADER_SECOND: hs = v;
				CFG_MOTION_CMD:    mcmd = v;
				CFG_REFEREE_CMD:   rcmd = v;
				CFG_MAX_PAYLOAD:   maxlen = v;
				CFG_CRC_POLY:      poly = v;
				CFG_CRC_REFLECTED: refl = v[0];
				CFG_CRC_INIT:      init = v;
				default: ;
			endcase
			build_table();
		endfunction

		function void take_byte(logic [7:0] b, output event_t ev, output logic [7:0] len);
			ev = EV_NONE;
			len = 8'd0;
			case (phase)
				PH_HUNT2: begin
					if (b == hs) begin
						crc = crc_next(crc, b);
						phase = PH_CMD;
					end else if (b == hf) begin
						crc = crc_next(init, b);
					end else begin
						phase = PH_HUNT1;
					end
				end
				PH_CMD: begin
					if (b != mcmd && b != rcmd) begin
						ev = EV_BAD_CMD;
						phase = PH_HUNT1;
					end else begin
						cmd = b;
						crc = crc_next(crc, b);
						phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (b > maxlen) begin
						ev = EV_TOO_LONG;
						len = b;
						phase = PH_HUNT1;
					end else begin
						flen = b;
						count = 8'd0;
						crc = crc_next(crc, b);
						phase = (b == 8'd0) ? PH_CRC : PH_DATA;
					end
				end
				PH_DATA: begin
					staging[count] = b;
					count = count + 8'd1;
					crc = crc_next(crc, b);
					if (count >= flen) begin
						phase = PH_CRC;
					end
				end
				PH_CRC: begin
					len = flen;
					phase = PH_HUNT1;
					if (b != crc) begin
						ev = EV_CRC_FAIL;
					end else if (cmd == rcmd) begin
						if (flen == REF_N) begin
							for (int i = 0; i < REF_N; i++) referee[i] = staging[i];
							ready = 1'b1;
							ev = EV_REFEREE_OK;
						end else begin
							ev = EV_LEN_MISMATCH;
						end
					end else if (flen <= MOT_N) begin
						for (int i = 0; i < flen; i++) motion[i] = staging[i];
						ev = EV_MOTION_OK;
					end else begin
						ev = EV_LEN_MISMATCH;
					end
				end
				default: begin
					phase = PH_HUNT1;
					if (b == hf) begin
						crc = crc_next(init, b);
						phase = PH_HUNT2;
					end
				end
			endcase
		endfunction

		function void note_beat(beat_t b);
			res_t r;
			r.ev = EV_NONE;
			r.len = 8'd0;
			r.rd = 8'd0;
			case (b.kind)
				REQ_BYTE:       take_byte(b.data, r.ev, r.len);
				REQ_RD_MOTION:  r.rd = (b.idx < MOT_N) ? motion[b.idx] : 8'd0;
				REQ_RD_REFEREE: r.rd = (b.idx < REF_N) ? referee[b.idx] : 8'd0;
				default:        ready = 1'b0;
			endcase
			r.ready = ready;
			pending.push_back(r);
			beats_noted++;
		endfunction

		function void flag_mismatch(string what);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $time, what);
			end
		endfunction

		function void check_result(logic [23:0] w);
			res_t want;
			checked++;
			ev_seen[w[2:0]]++;
			if (pending.size() == 0) begin
				flag_mismatch($sformatf(
					"result with nothing expected: ev=%0d len=%0d rd=%0d ready=%0d",
					w[2:0], w[10:3], w[18:11], w[19]));
				return;
			end
			want = pending.pop_front();
			if (w[2:0] !== want.ev || w[10:3] !== want.len || w[18:11] !== want.rd ||
					w[19] !== want.ready || w[23:20] !== 4'd0) begin
				flag_mismatch($sformatf({"expected ev=%0d len=%0d rd=%0d ready=%0d, ",
					"got ev=%0d len=%0d rd=%0d ready=%0d fill=%h"},
					want.ev, want.len, want.rd, want.ready,
					w[2:0], w[10:3], w[18:11], w[19], w[23:20]));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic [1:0]  s_tuser = REQ_BYTE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_HEADER_FIRST;
	logic [7:0]  cfg_wdata = 8'd0;

	frame_outcome_board sb = new();
	beat_t beat_q [$];
	int    stim_count = 0;
	int    send_idle = 0;
	int    recv_idle = 0;
	int    settings = 0;

	serial_frame_parser_crc8 #(
		.STAGE_DEPTH(STAGE_N),
		.MOTION_BYTES(MOT_N),
		.REFEREE_BYTES(REF_N)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_beat(beat_q.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (beat_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tuser <= beat_q[0].kind;
					s_tdata <= {2'b00, beat_q[0].idx, beat_q[0].data};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic push_beat(req_t k, logic [7:0] d, logic [5:0] i);
		beat_q.push_back('{kind: k, data: d, idx: i});
		stim_count++;
	endtask

	task automatic push_byte(logic [7:0] d);
		push_beat(REQ_BYTE, d, 6'($urandom_range(63)));
	endtask

	task automatic push_frame(logic [7:0] cmd, logic [7:0] len, bit good_crc, bit dup_head,
			int keep);
		logic [7:0] bytes [$];
		logic [7:0] c;
		if (dup_head) bytes.push_back(sb.hf);
		bytes.push_back(sb.hf);
		bytes.push_back(sb.hs);
		bytes.push_back(cmd);
		bytes.push_back(len);
		if (len <= sb.maxlen) begin
			for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(255)));
			c = sb.init;
			for (int i = dup_head; i < bytes.size(); i++) c = sb.crc_next(c, bytes[i]);
			bytes.push_back(good_crc ? c : c ^ 8'($urandom_range(255, 1)));
		end
		if (keep > 0 && keep < bytes.size()) bytes = bytes[0:keep - 1];
		foreach (bytes[i]) push_byte(bytes[i]);
	endtask

	task automatic gen_random(int n);
		int goal;
		int r;
		int m;
		logic [7:0] cmd;
		logic [7:0] len;
		goal = stim_count + n;
		while (stim_count < goal) begin
			r = $urandom_range(99);
			cmd = $urandom_range(1) ? sb.mcmd : sb.rcmd;
			m = $urandom_range(99);
			if (cmd == sb.rcmd && m < 70) len = 8'(REF_N);
			else if (m < 88) len = 8'($urandom_range(MOT_N));
			else if (m < 99) len = 8'($urandom_range(MOT_N + 16, MOT_N + 1));
			else len = 8'($urandom_range(255, MOT_N + 17));
			if (r < 45) begin
				push_frame(cmd, len, $urandom_range(9) != 0, $urandom_range(9) == 0, 0);
			end else if (r < 52) begin
				push_frame(cmd, len, 1'b1, 1'b0, $urandom_range(8, 2));
			end else if (r < 56) begin
				push_frame(8'($urandom_range(255)), len, 1'b1, 1'($urandom_range(1)), 3);
			end else if (r < 70) begin
				push_beat(REQ_RD_MOTION, 8'($urandom_range(255)), 6'($urandom_range(63)));
			end else if (r < 80) begin
				push_beat(REQ_RD_REFEREE, 8'($urandom_range(255)), 6'($urandom_range(63)));
			end else if (r < 85) begin
				push_beat(REQ_CLEAR, 8'($urandom_range(255)), 6'($urandom_range(63)));
			end else begin
				push_byte($urandom_range(3) == 0 ? sb.hf : 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic set_register(cfg_idx_t i, logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_wdata <= v;
		sb.write_reg(i, v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (beat_q.size() != 0 || s_tvalid || sb.pending.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic apply_setting(int p);
		logic [7:0] v [8];
		case (p)
			1: v = '{8'hA5, 8'h5A, 8'h10, 8'h20, 8'hFF, 8'h31, 8'h01, 8'hFF};
			2: v = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
			3: v = '{8'hFF, 8'h00, 8'h7E, 8'h7E, 8'd20, 8'hFF, 8'h01, 8'h00};
			5: v = '{8'h42, 8'h52, 8'hCD, 8'h00, 8'hFF, 8'h9B, 8'h00, 8'h5C};
			default: begin
				foreach (v[i]) v[i] = 8'($urandom_range(255));
				while (v[CFG_HEADER_SECOND] == v[CFG_HEADER_FIRST])
					v[CFG_HEADER_SECOND] = 8'($urandom_range(255));
				while (v[CFG_REFEREE_CMD] == v[CFG_MOTION_CMD])
					v[CFG_REFEREE_CMD] = 8'($urandom_range(255));
				v[CFG_MAX_PAYLOAD] = 8'($urandom_range(255, 16));
			end
		endcase
		for (int i = 0; i < 8; i++) set_register(cfg_idx_t'(i), v[i]);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 7; p++) begin
			send_idle = (p < 3) ? 25 : (p < 5) ? 59 : 0;
			recv_idle = (p < 3) ? 59 : (p < 5) ? 25 : 0;
			if (p > 0) begin
				wait_drained();
				apply_setting(p);
			end
			settings++;
			@(negedge clk);
			if (p == 0) begin
				push_beat(REQ_RD_MOTION, 8'h00, 6'd0);
				push_beat(REQ_RD_MOTION, 8'hFF, 6'd63);
				push_beat(REQ_RD_REFEREE, 8'h00, 6'(REF_N - 1));
				push_beat(REQ_RD_REFEREE, 8'hFF, 6'(REF_N));
				push_beat(REQ_CLEAR, 8'h00, 6'd0);
				push_frame(sb.mcmd, 8'd0, 1'b1, 1'b0, 0);
				push_frame(sb.rcmd, 8'd0, 1'b1, 1'b0, 0);
				push_byte(sb.hf);
				push_byte(8'h11);
				push_frame(8'h11, 8'd0, 1'b1, 1'b1, 4);
				push_frame(sb.mcmd, 8'd2, 1'b0, 1'b0, 0);
				push_beat(REQ_RD_MOTION, 8'h00, 6'd1);
			end
			gen_random((p == 2) ? 40 : 75);
		end
		wait_drained();
		$display("Drove %0d beats over %0d register settings; %0d results checked.",
			sb.beats_noted, settings, sb.checked);
		$display({"Frames: %0d motion and %0d referee committed, %0d bad command, ",
			"%0d too long, %0d CRC failures, %0d length mismatches."},
			sb.ev_seen[EV_MOTION_OK], sb.ev_seen[EV_REFEREE_OK], sb.ev_seen[EV_BAD_CMD],
			sb.ev_seen[EV_TOO_LONG], sb.ev_seen[EV_CRC_FAIL], sb.ev_seen[EV_LEN_MISMATCH]);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("serial_frame_parser_crc8_tb: PASS");
		end else begin
			$display("serial_frame_parser_crc8_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected.", sb.pending.size());
		$display("serial_frame_parser_crc8_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sfp_pkg.sv
rtl/core/sfp_queue.sv
rtl/core/sfp_front.sv
rtl/core/sfp_back.sv
rtl/core/serial_frame_parser_crc8.sv
tb/serial_frame_parser_crc8_tb.sv
